>>> hw/rtl/sha256_pkg.sv
// shared types, round constants and sigma functions for the sha-256 hasher
package sha256_pkg;

  typedef logic [31:0] word_t;

  // input transfer: one message byte or a finish command
  typedef struct packed {
    logic       op;
    logic [7:0] msg_byte;
  } msg_t;

  // output transfer: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dig_t;

  // sequencer controls for the round unit
  typedef struct packed {
    logic load;   // copy chaining words into working variables
    logic round;  // run one compression round
    logic add;    // fold working variables into chaining words
    logic iv;     // restore initial hash values
  } sha256_ctl_t;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned RND_W  = $clog2(ROUNDS);

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TABLE [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

>>> hw/rtl/sha256_sched.sv
// block buffer shift line that doubles as the rolling message schedule
module sha256_sched
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       byte_en,
  input  logic [7:0] byte_val,
  input  logic       sched_en,
  output word_t      w
);

  // 64 bytes, first byte ends up in the top bits; word i sits at [511-32i -: 32]
  logic [511:0] blk;
  word_t        w_new;

  assign w = blk[511:480];

  // next schedule word from taps at window positions 0, 1, 9 and 14
  assign w_new = ssig1(blk[63:32]) + blk[223:192] + ssig0(blk[479:448]) + blk[511:480];

  always_ff @(posedge clk) begin
    if (byte_en) begin
      blk <= {blk[503:0], byte_val};
    end else if (sched_en) begin
      blk <= {blk[479:0], w_new};
    end
  end

endmodule

>>> hw/rtl/sha256_round.sv
// working variables, one-round-per-cycle compression step and chaining words
module sha256_round
  import sha256_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  sha256_ctl_t      ctl,
  input  logic [RND_W-1:0] rnd,
  input  word_t            w,
  output word_t            chain [8]
);

  word_t v [8];
  word_t ch, maj, t1, t2;

  assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1  = v[7] + bsig1(v[4]) + ch + K_TABLE[rnd] + w;
  assign t2  = bsig0(v[0]) + maj;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int j = 0; j < 8; j++) v[j] <= chain[j];
    end else if (ctl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.iv) begin
      for (int j = 0; j < 8; j++) chain[j] <= IV[j];
    end else if (ctl.add) begin
      for (int j = 0; j < 8; j++) chain[j] <= chain[j] + v[j];
    end
  end

endmodule

>>> hw/rtl/sha256_stream_hasher.sv
// sha-256 over a byte stream: sequencer, padding and digest output register
//
// usage
// - input channel msg_valid / msg_stall / msg: one transfer per message byte
//   (op absorb) or one finish transfer (op finish, byte ignored)
// - output channel dig_valid / dig_stall / dig: eight digest words per finish,
//   word 0 (most significant) first, last_word set on word 7
// - the byte that completes a 64-byte block is followed by the compression
//   rounds and the chaining add, during which no new byte is taken; the
//   single round unit runs one round per clock
// - finish: padding bytes go through the buffer one per cycle (64 - fill, or
//   128 - fill when 8 or fewer bytes of room remain, which adds an extra
//   block), then the last block is compressed, then 8 word transfers
// - msg_stall is high whenever the sequencer is not idle
// - the digest sits in an output register; a stalled receiver holds the word
//   and the emit phase waits, while after the eighth word is loaded the block
//   takes new bytes even if that word has not been taken yet
// - after the eighth word the block returns to its initial state by itself
// - synchronous active-high rst restores the initial hash values and clears
//   the byte and block counters; no clearing pass is needed
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic msg_valid,
  output logic msg_stall,
  input  msg_t msg,
  output logic dig_valid,
  input  logic dig_stall,
  output dig_t dig
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COMP = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_PAD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]       state;
  logic [5:0]       fill;         // bytes in the block buffer
  logic [54:0]      block_count;  // full data blocks, wraps with the bit length
  logic [5:0]       fin_fill;     // fill at the finish transfer
  logic             fin;          // finish in progress
  logic             lenok;        // length may go into bytes 56..63 of this block
  logic             first;        // next pad byte is the 0x80 marker
  logic [RND_W-1:0] rnd;
  logic [2:0]       idx;

  logic        accept;
  logic        byte_en;
  logic [7:0]  byte_val;
  logic [7:0]  pad_byte;
  logic [7:0]  len_byte;
  logic [63:0] msg_len;
  logic [2:0]  lsel;
  logic        block_full;
  logic        out_load;
  logic        sched_en;
  sha256_ctl_t ctl;
  word_t       w;
  word_t       chain [8];

  assign msg_stall = (state != ST_IDLE);
  assign accept    = msg_valid && !msg_stall;

  // message length in bits, big-endian bytes picked by buffer position
  assign msg_len  = {block_count, fin_fill, 3'b000};
  assign lsel     = ~fill[2:0];
  assign len_byte = msg_len[{lsel, 3'b000} +: 8];

  always_comb begin
    if (first) begin
      pad_byte = 8'h80;
    end else if (lenok && (fill[5:3] == 3'b111)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign byte_en    = (accept && (msg.op == OP_ABSORB)) || (state == ST_PAD);
  assign byte_val   = (state == ST_PAD) ? pad_byte : msg.msg_byte;
  assign block_full = byte_en && (fill == 6'd63);
  assign sched_en   = (state == ST_COMP);
  assign out_load   = (state == ST_EMIT) && (!dig_valid || !dig_stall);

  assign ctl.load  = block_full;
  assign ctl.round = (state == ST_COMP);
  assign ctl.add   = (state == ST_ADD);
  assign ctl.iv    = out_load && (idx == 3'd7);

  sha256_sched u_sched (
    .clk      (clk),
    .byte_en  (byte_en),
    .byte_val (byte_val),
    .sched_en (sched_en),
    .w        (w)
  );

  sha256_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .rnd   (rnd),
    .w     (w),
    .chain (chain)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      block_count <= '0;
      fin         <= 1'b0;
      lenok       <= 1'b0;
      first       <= 1'b0;
      rnd         <= '0;
      idx         <= '0;
    end else begin
      // buffer position wraps to zero as the block fills
      if (byte_en) begin
        fill <= fill + 6'd1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (msg.op == OP_FINISH) begin
              state <= ST_PAD;
              fin   <= 1'b1;
              first <= 1'b1;
              lenok <= (fill[5:3] != 3'b111);
            end else if (block_full) begin
              state <= ST_COMP;
            end
          end
        end
        ST_PAD: begin
          first <= 1'b0;
          if (block_full) begin
            state <= ST_COMP;
          end
        end
        ST_COMP: begin
          rnd <= rnd + RND_W'(1);
          if (rnd == RND_W'(ROUNDS - 1)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (!fin) begin
            block_count <= block_count + 55'd1;
            state       <= ST_IDLE;
          end else if (!lenok) begin
            // extra block went out, length goes into the next one
            lenok <= 1'b1;
            state <= ST_PAD;
          end else begin
            idx   <= '0;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              state       <= ST_IDLE;
              block_count <= '0;
              fin         <= 1'b0;
              lenok       <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // fill count at finish, frozen for the length field
  always_ff @(posedge clk) begin
    if (accept && (msg.op == OP_FINISH)) begin
      fin_fill <= fill;
    end
  end

  // digest output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dig_valid <= 1'b0;
    end else if (out_load) begin
      dig_valid <= 1'b1;
    end else if (!dig_stall) begin
      dig_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dig.digest_word <= chain[idx];
      dig.word_index  <= idx;
      dig.last_word   <= (idx == 3'd7);
    end
  end

  // a new digest word only comes from the emit phase
  a_dig_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(dig_valid) |-> ($past(state) == ST_EMIT))
    else $error("digest transfer started outside emit phase");

  // rounds and the chaining add always see an empty buffer position
  a_fill_wrapped: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_COMP) || (state == ST_ADD)) |-> (fill == 6'd0))
    else $error("buffer position not wrapped during compression");

  // a finish transfer always starts padding
  a_finish_pads: assert property (@(posedge clk) disable iff (rst)
    (accept && (msg.op == OP_FINISH)) |=> (state == ST_PAD) && first)
    else $error("finish transfer did not start padding");

  // last_word marks word seven only
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig.last_word) |-> (dig.word_index == 3'd7))
    else $error("last word flag on wrong index");

endmodule

>>> dv/tb_sha256_stream_hasher.sv
// self-checking testbench for the sha-256 byte stream hasher
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;
  import sha256_pkg::*;

  // longest quiet stretch: a finish that needs the extra block pads the rest
  // of two blocks and compresses both before the first digest word, with
  // sender gaps on top; this is several times over
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned RANDOM_ITEMS   = 166;

  // well-known digests of the empty message and of "abc"
  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_CHAIN [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // directed row: op, byte, whether the digest is typed in, typed digest
  typedef struct packed {
    logic         op;
    logic [7:0]   msg_byte;
    logic         typed;
    logic [255:0] digest;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 14;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // empty message straight out of reset
    {OP_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
    // "abc", with a nonzero byte on the finish transfer that must be ignored
    {OP_ABSORB, 8'h61, 1'b0, 256'h0},
    {OP_ABSORB, 8'h62, 1'b0, 256'h0},
    {OP_ABSORB, 8'h63, 1'b0, 256'h0},
    {OP_FINISH, 8'hff, 1'b1, ABC_DIGEST},
    // byte extremes
    {OP_ABSORB, 8'h00, 1'b0, 256'h0},
    {OP_ABSORB, 8'hff, 1'b0, 256'h0},
    {OP_FINISH, 8'ha5, 1'b0, 256'h0},
    {OP_ABSORB, 8'h80, 1'b0, 256'h0},
    {OP_ABSORB, 8'h7f, 1'b0, 256'h0},
    {OP_FINISH, 8'h00, 1'b0, 256'h0},
    // empty message again, after the self-restart of a finish
    {OP_FINISH, 8'hff, 1'b1, EMPTY_DIGEST},
    {OP_ABSORB, 8'hff, 1'b0, 256'h0},
    {OP_FINISH, 8'h5a, 1'b0, 256'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_stall;
  msg_t msg = '0;
  logic dig_valid;
  logic dig_stall = 1'b0;
  dig_t dig;

  always #5 clk = ~clk;

  sha256_stream_hasher uut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  // predictor state: chaining words, partial block and message length so far
  logic [31:0] hash_chain [8];
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  dig_t        digest_queue [$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  logic        calm_run = 1'b0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_hash();
    hash_chain = INIT_CHAIN;
    block_fill = 0;
    msg_bits   = 64'd0;
  endfunction

  // one 64-round compression of msg_block into hash_chain
  function automatic void compress_block();
    logic [31:0] sched [16];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2, x2, x15;
    for (int t = 0; t < 16; t++)
      sched[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int j = 0; j < 8; j++)
      v[j] = hash_chain[j];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        // rolling schedule: slot t%16 still holds w[t-16]
        x2  = sched[(t - 2) % 16];
        x15 = sched[(t - 15) % 16];
        s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        sched[t % 16] = s1 + sched[(t - 7) % 16] + s0 + sched[t % 16];
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + sched[t % 16];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++)
      hash_chain[j] = hash_chain[j] + v[j];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill++;
    if (block_fill == 64) begin
      compress_block();
      msg_bits   = msg_bits + 64'd512;
      block_fill = 0;
    end
  endfunction

  // pad, compress the tail, hand back the digest and start a new message
  function automatic logic [255:0] finish_message();
    int unsigned i;
    logic [255:0] d;
    i = block_fill;
    msg_block[i] = 8'h80;
    i++;
    // no room for the length field: the padding spills into an extra block
    if (block_fill >= 56) begin
      while (i < 64) begin
        msg_block[i] = 8'h00;
        i++;
      end
      compress_block();
      i = 0;
    end
    while (i < 56) begin
      msg_block[i] = 8'h00;
      i++;
    end
    msg_bits = msg_bits + 64'(block_fill) * 64'd8;
    for (int k = 0; k < 8; k++)
      msg_block[56 + k] = msg_bits[63 - 8*k -: 8];
    compress_block();
    for (int k = 0; k < 8; k++)
      d[255 - 32*k -: 32] = hash_chain[k];
    restart_hash();
    return d;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // one input transfer, with random idle cycles ahead of it, then the
  // predictor update; a typed digest replaces the predicted one
  task automatic transfer_item(input logic op, input logic [7:0] b,
                               input logic use_typed, input logic [255:0] typed_digest);
    logic [255:0] d;
    dig_t word;
    while (!calm_run && $urandom_range(99) < 8) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= {op, b};
    do @(posedge clk); while (msg_stall);
    if (op == OP_ABSORB) begin
      absorb_byte(b);
    end else begin
      d = finish_message();
      if (use_typed)
        d = typed_digest;
      for (int k = 0; k < 8; k++) begin
        word.digest_word = d[255 - 32*k -: 32];
        word.word_index  = 3'(k);
        word.last_word   = (k == 7);
        digest_queue.push_back(word);
      end
    end
  endtask

  // digest receiver: random stalls, field-by-field compare on each transfer
  always @(posedge clk) begin
    dig_t want;
    if (rst) begin
      dig_stall <= 1'b0;
    end else begin
      if (dig_valid && !dig_stall) begin
        if (digest_queue.size() == 0) begin
          report_mismatch("unexpected digest_word", dig.digest_word, 32'h0);
        end else begin
          want = digest_queue.pop_front();
          if (dig.digest_word !== want.digest_word)
            report_mismatch("digest_word", dig.digest_word, want.digest_word);
          if (dig.word_index !== want.word_index)
            report_mismatch("word_index", 32'(dig.word_index), 32'(want.word_index));
          if (dig.last_word !== want.last_word)
            report_mismatch("last_word", 32'(dig.last_word), 32'(want.last_word));
        end
      end
      dig_stall <= !calm_run && ($urandom_range(99) < 8);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (msg_valid && !msg_stall) || (dig_valid && !dig_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("tb_sha256_stream_hasher: errors");
      $finish;
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned msg_len;
    restart_hash();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    for (int r = 0; r < DIRECTED_ROWS; r++)
      transfer_item(DIRECTED[r].op, DIRECTED[r].msg_byte, DIRECTED[r].typed,
                    DIRECTED[r].digest);

    // random messages: mostly short, the rest around the block boundary and
    // the extra-block padding threshold
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(9) < 6) begin
        msg_len = $urandom_range(12);
      end else begin
        case ($urandom_range(5))
          0: msg_len = 55;
          1: msg_len = 56;
          2: msg_len = 57;
          3: msg_len = 63;
          4: msg_len = 64;
          default: msg_len = 65;
        endcase
      end
      for (int n = 0; n < msg_len; n++) begin
        // middle stretch runs with no idling on either side
        calm_run <= (rand_items >= 60 && rand_items < 120);
        transfer_item(OP_ABSORB, 8'($urandom_range(255)), 1'b0, 256'h0);
        rand_items++;
      end
      transfer_item(OP_FINISH, 8'($urandom_range(255)), 1'b0, 256'h0);
      rand_items++;
    end
    msg_valid <= 1'b0;
    calm_run  <= 1'b0;

    // wait for the last digest, then watch for stray words
    while (digest_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("tb_sha256_stream_hasher: clean");
    else
      $display("tb_sha256_stream_hasher: errors");
    $finish;
  end

endmodule

>>> sha256_stream_hasher.f
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_sched.sv
hw/rtl/sha256_round.sv
hw/rtl/sha256_stream_hasher.sv
dv/tb_sha256_stream_hasher.sv
